/* design/pca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants of the page allocator: field widths, request
// modes, result codes, register indexes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pca_pkg;

   // Field widths
   localparam int MODE_W       = 2;
   localparam int PAGE_FIELD_W = 10;
   localparam int LAYER_W      = 8;
   localparam int STATUS_W     = 2;
   localparam int ADDR_W       = 48;
   localparam int LAYERS_W     = 8;
   localparam int BYTES_W      = 24;
   localparam int LIMIT_W      = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 48;

   // Bitmap row geometry: one memory word holds the free bits of 32 pages
   localparam int ROW_BITS  = 32;
   localparam int ROW_SHIFT = 5;

   // Address arithmetic widths
   localparam int PROD1_W = PAGE_FIELD_W + LAYERS_W;
   localparam int SLOT_W  = PROD1_W + 2;
   localparam int PROD2_W = SLOT_W + BYTES_W;

   // Reset values of the configuration registers
   localparam logic [ADDR_W-1:0]   BASE_RESET   = '0;
   localparam logic [LAYERS_W-1:0] LAYERS_RESET = 8'd1;
   localparam logic [BYTES_W-1:0]  BYTES_RESET  = 24'd4096;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_KEY   = 2'd2,
      MODE_VALUE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BASE   = 2'd0,
      REG_LAYERS = 2'd1,
      REG_BYTES  = 2'd2,
      REG_LIMIT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR    = 3'd0,
      S_IDLE     = 3'd1,
      S_DISPATCH = 3'd2,
      S_SCAN     = 3'd3,
      S_FREE_WR  = 3'd4,
      S_ADDR_MUL = 3'd5,
      S_ADDR_SUM = 3'd6,
      S_DONE     = 3'd7
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;     // latch the request item
      logic       clear_wr;    // write an all-free row, advance clear pointer
      logic       scan_first;  // read bitmap row 0
      logic       scan_next;   // read the next bitmap row
      logic       scan_claim;  // write back the row with the claimed bit cleared
      logic       free_rd;     // read the row of the page to free
      logic       free_wr;     // write back the row with the page bit set
      logic       mul_slot;    // page * layer_count
      logic       mul_bytes;   // slot * layer_page_bytes
      logic       res_set;     // load the result holding registers
      logic       res_grant;   // result carries the claimed page
      logic       res_addr;    // result carries the computed address
      status_type res_status;
      logic       out_load;    // move the result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic     clear_last;
      mode_type mode;
      logic     lim_zero;
      logic     page_in_range;
      logic     row_found;
      logic     row_last;
      logic     out_free;
   } stat_type;

endpackage
`default_nettype wire

/* design/pca_chan_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page allocator channels
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface pca_req_if;
   logic                              valid;
   logic                              ready;
   logic [pca_pkg::MODE_W-1:0]        mode;
   logic [pca_pkg::PAGE_FIELD_W-1:0]  page_index;
   logic [pca_pkg::LAYER_W-1:0]       layer;

   modport source (output valid, mode, page_index, layer, input ready);
   modport sink   (input valid, mode, page_index, layer, output ready);
endinterface

interface pca_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pca_pkg::STATUS_W-1:0]      status;
   logic [pca_pkg::PAGE_FIELD_W-1:0]  granted_page;
   logic [pca_pkg::ADDR_W-1:0]        address;

   modport source (output valid, status, granted_page, address, input ready);
   modport sink   (input valid, status, granted_page, address, output ready);
endinterface

interface pca_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pca_pkg::CSR_INDEX_W-1:0]   index;
   logic [pca_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/pca_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module pca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/pca_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_ctrl
// Controller of the page allocator: clearing pass after reset, request
// dispatch, bitmap scan, read-modify-write of a freed page, address
// sequence and result hand-off.
// ----------------------------------------------------------------------------
module pca_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire pca_pkg::stat_type  stat,
   output      pca_pkg::cmd_type   cmd
);

   import pca_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_ALLOC: state_in = stat.lim_zero ? S_DONE : S_SCAN;
               MODE_FREE:  state_in = stat.page_in_range ? S_FREE_WR : S_DONE;
               default:    state_in = S_ADDR_MUL;
            endcase
         end
         S_SCAN: begin
            if (stat.row_found || stat.row_last) begin
               state_in = S_DONE;
            end
         end
         S_FREE_WR:  state_in = S_DONE;
         S_ADDR_MUL: state_in = S_ADDR_SUM;
         S_ADDR_SUM: state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_ALLOC: begin
                  if (stat.lim_zero) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_NO_FREE;
                  end else begin
                     cmd.scan_first = 1'b1;
                  end
               end
               MODE_FREE: begin
                  if (stat.page_in_range) begin
                     cmd.free_rd = 1'b1;
                  end else begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_RANGE;
                  end
               end
               default: begin
                  cmd.mul_slot = 1'b1;
               end
            endcase
         end
         S_SCAN: begin
            if (stat.row_found) begin
               cmd.scan_claim = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_grant  = 1'b1;
               cmd.res_status = ST_OK;
            end else if (stat.row_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NO_FREE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_FREE_WR: begin
            cmd.free_wr    = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
         end
         S_ADDR_MUL: begin
            cmd.mul_bytes = 1'b1;
         end
         S_ADDR_SUM: begin
            cmd.res_set    = 1'b1;
            cmd.res_addr   = 1'b1;
            cmd.res_status = ST_OK;
         end
         S_DONE: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

/* design/pca_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pca_datapath
// Datapath of the page allocator: configuration registers, free bitmap
// memory with row scan and priority pick, slot address multipliers and
// the result and output registers.
// ----------------------------------------------------------------------------
module pca_datapath #(
   parameter int PAGE_CAPACITY = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pca_pkg::cmd_type                   cmd,
   output      pca_pkg::stat_type                  stat,
   input  wire logic [pca_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [pca_pkg::PAGE_FIELD_W-1:0]   req_page_index,
   input  wire logic [pca_pkg::LAYER_W-1:0]        req_layer,
   input  wire logic                               csr_valid,
   input  wire logic [pca_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pca_pkg::CSR_DATA_W-1:0]     csr_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [pca_pkg::STATUS_W-1:0]       rsp_status,
   output      logic [pca_pkg::PAGE_FIELD_W-1:0]   rsp_granted_page,
   output      logic [pca_pkg::ADDR_W-1:0]         rsp_address
);

   import pca_pkg::*;

   localparam int ROWS  = (PAGE_CAPACITY + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int MAXP_W = 17;

   // Configuration registers
   logic [ADDR_W-1:0]   base_ff;
   logic [LAYERS_W-1:0] layers_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   // Captured request
   mode_type               mode_ff;
   logic [PAGE_FIELD_W-1:0] page_ff;
   logic [LAYER_W-1:0]     layer_ff;

   // Scan and clear pointers
   logic [ROW_W-1:0] check_row_ff, check_row_in;
   logic [ROW_W-1:0] clear_row_ff, clear_row_in;

   // Address pipeline
   logic [PROD1_W-1:0] prod1_ff;
   logic [PROD2_W-1:0] prod2_ff;
   logic [SLOT_W-1:0]  slot;

   // Result holding and output registers
   status_type              res_status_ff;
   logic [PAGE_FIELD_W-1:0] res_page_ff;
   logic [ADDR_W-1:0]       res_addr_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [PAGE_FIELD_W-1:0] rsp_page_ff;
   logic [ADDR_W-1:0]       rsp_addr_ff;

   // Bitmap memory ports
   logic                ram_wr_en;
   logic [ROW_W-1:0]    ram_wr_addr;
   logic [ROW_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [ROW_W-1:0]    ram_rd_addr;
   logic [ROW_BITS-1:0] ram_rd_data;

   // Limit and row decode
   logic [LIMIT_W-1:0]   lim;
   logic [LIMIT_W-1:0]   lim_m1;
   logic [31:0]          lim_row_w;
   logic [31:0]          last_row_w;
   logic [31:0]          check_row_w;
   logic [ROW_SHIFT-1:0] lim_bit;
   logic [ROW_BITS-1:0]  row_mask;
   logic [ROW_BITS-1:0]  masked;
   logic [ROW_BITS-1:0]  pick;
   logic [ROW_SHIFT-1:0] pick_idx;
   logic [31:0]          claim_page;
   logic [31:0]          page_w;
   logic [ROW_W-1:0]     free_row;
   logic [ROW_SHIFT-1:0] free_bit;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         layers_ff <= LAYERS_RESET;
         bytes_ff  <= BYTES_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_BASE:   base_ff   <= csr_data[ADDR_W-1:0];
            REG_LAYERS: layers_ff <= csr_data[LAYERS_W-1:0];
            REG_BYTES:  bytes_ff  <= csr_data[BYTES_W-1:0];
            REG_LIMIT:  limit_ff  <= csr_data[LIMIT_W-1:0];
            default:    base_ff   <= base_ff;
         endcase
      end
   end

   // Capture the request item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         page_ff  <= req_page_index;
         layer_ff <= req_layer;
      end
   end

   // Effective page limit: min(pages_in_use, PAGE_CAPACITY)
   always_comb begin
      lim = (MAXP_W'(limit_ff) < MAXP_W'(PAGE_CAPACITY)) ? limit_ff : LIMIT_W'(PAGE_CAPACITY);
      lim_m1      = lim - LIMIT_W'(1);
      lim_row_w   = 32'(lim[LIMIT_W-1:ROW_SHIFT]);
      last_row_w  = 32'(lim_m1[LIMIT_W-1:ROW_SHIFT]);
      lim_bit     = lim[ROW_SHIFT-1:0];
      check_row_w = 32'(check_row_ff);
   end

   // Pages of the scanned row that lie below the limit
   always_comb begin
      if (check_row_w < lim_row_w) begin
         row_mask = '1;
      end else if (check_row_w == lim_row_w) begin
         row_mask = (ROW_BITS'(1) << lim_bit) - ROW_BITS'(1);
      end else begin
         row_mask = '0;
      end
   end

   // Pick the lowest free page of the row
   always_comb begin
      masked   = ram_rd_data & row_mask;
      pick     = masked & (~masked + ROW_BITS'(1));
      pick_idx = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         if (pick[i]) begin
            pick_idx = pick_idx | ROW_SHIFT'(i);
         end
      end
      claim_page = (check_row_w << ROW_SHIFT) | 32'(pick_idx);
   end

   // Row and bit of the page to free
   always_comb begin
      page_w   = 32'(page_ff);
      free_row = page_w[ROW_W+ROW_SHIFT-1:ROW_SHIFT];
      free_bit = page_ff[ROW_SHIFT-1:0];
   end

   // Pointers
   always_comb begin
      check_row_in = check_row_ff;
      if (cmd.scan_first) begin
         check_row_in = '0;
      end else if (cmd.scan_next) begin
         check_row_in = check_row_ff + ROW_W'(1);
      end
      clear_row_in = cmd.clear_wr ? clear_row_ff + ROW_W'(1) : clear_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_row_ff <= '0;
         clear_row_ff <= '0;
      end else begin
         check_row_ff <= check_row_in;
         clear_row_ff <= clear_row_in;
      end
   end

   // Bitmap memory port selection
   always_comb begin
      ram_rd_en   = cmd.scan_first | cmd.scan_next | cmd.free_rd;
      ram_rd_addr = free_row;
      if (cmd.scan_first) begin
         ram_rd_addr = '0;
      end else if (cmd.scan_next) begin
         ram_rd_addr = check_row_in;
      end
      ram_wr_en   = cmd.clear_wr | cmd.scan_claim | cmd.free_wr;
      ram_wr_addr = free_row;
      ram_wr_data = ram_rd_data | (ROW_BITS'(1) << free_bit);
      if (cmd.clear_wr) begin
         ram_wr_addr = clear_row_ff;
         ram_wr_data = '1;
      end else if (cmd.scan_claim) begin
         ram_wr_addr = check_row_ff;
         ram_wr_data = ram_rd_data & ~pick;
      end
   end

   pca_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Slot address: (page*layers*2 + layer*2 + k) * bytes, one multiply a stage
   assign slot = SLOT_W'({prod1_ff, 1'b0}) + SLOT_W'({layer_ff, (mode_ff == MODE_VALUE)});

   always_ff @(posedge clock) begin
      if (cmd.mul_slot) begin
         prod1_ff <= PROD1_W'(page_ff) * PROD1_W'(layers_ff);
      end
      if (cmd.mul_bytes) begin
         prod2_ff <= PROD2_W'(slot) * PROD2_W'(bytes_ff);
      end
   end

   // Result holding registers
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_page_ff   <= cmd.res_grant ? claim_page[PAGE_FIELD_W-1:0] : '0;
         res_addr_ff   <= cmd.res_addr ? base_ff + ADDR_W'(prod2_ff) : '0;
      end
   end

   // Output register: load on hand-off, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_page_ff   <= res_page_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_page = rsp_page_ff;
   assign rsp_address      = rsp_addr_ff;

   // Status to the controller
   always_comb begin
      stat.clear_last    = (clear_row_ff == ROW_W'(ROWS - 1));
      stat.mode          = mode_ff;
      stat.lim_zero      = (lim == '0);
      stat.page_in_range = (LIMIT_W'(page_ff) < lim);
      stat.row_found     = |masked;
      stat.row_last      = (check_row_w >= last_row_w);
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire

/* design/paged_cache_page_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_cache_page_allocator
// Page allocator for a paged key/value store: first-fit free bitmap plus
// key and value slot address generation.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request item (mode, page_index, layer); rsp_ch returns
//   exactly one result item (status, granted_page, address) per request, in
//   order. csr_ch writes the four registers (base address, layer count,
//   layer page bytes, pages in use); it is always ready. The user must write
//   it only while no request is in flight; the block does not enforce this.
//   One request is processed at a time: dispatch, then a bitmap row write
//   (free; none when out of range), a second multiply and the base add
//   (key/value address, first multiply in dispatch) or a scan of 32-page
//   bitmap rows from row 0 until a free page is found (allocate: 1 to
//   ceil(limit/32) rows, none with an empty pool; one row is read per cycle).
//   The next request is taken once the result is in the output register.
//   After reset the bitmap memory is swept to all-free, one row per cycle:
//   ceil(PAGE_CAPACITY/32) rows (32 at the default), with req_ch not ready.
//   A stalled receiver holds the result in the output register; the block
//   still takes and processes one more request and then waits with it.
// ----------------------------------------------------------------------------
module paged_cache_page_allocator #(
   parameter int PAGE_CAPACITY = 1024
) (
   input wire logic  clock,
   input wire logic  reset,
   pca_req_if.sink   req_ch,
   pca_rsp_if.source rsp_ch,
   pca_csr_if.sink   csr_ch
);

   import pca_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   pca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pca_datapath #(
      .PAGE_CAPACITY (PAGE_CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_ch.mode),
      .req_page_index   (req_ch.page_index),
      .req_layer        (req_ch.layer),
      .csr_valid        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_granted_page (rsp_ch.granted_page),
      .rsp_address      (rsp_ch.address)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   // Requests are held off when the bitmap clearing pass starts after reset
   a_clear_blocks_req: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("request accepted during bitmap clearing pass");

   // One request at a time: no acceptance right after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second request accepted while one is in flight");

   // Error results carry neither a page nor an address
   a_error_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != ST_OK))
         |-> (rsp_ch.granted_page == '0) && (rsp_ch.address == '0))
      else $error("error result with nonzero page or address");

endmodule
`default_nettype wire
